// ===== src/biq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package biq_pkg;

  // number of coefficient registers and the width of their index
  localparam int unsigned NUM_COEFS  = 5;
  localparam int unsigned COEF_IDX_W = 3;

  // coefficient register map
  typedef enum logic [COEF_IDX_W-1:0] {
    IDX_B0 = 3'd0,
    IDX_B1 = 3'd1,
    IDX_B2 = 3'd2,
    IDX_A1 = 3'd3,
    IDX_A2 = 3'd4
  } coef_idx_e;

endpackage

`default_nettype wire

// ===== src/biq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// input sample channel
interface biq_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// filtered result channel
interface biq_filt_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// coefficient write channel
interface biq_cfg_if #(
  parameter int unsigned COEF_WIDTH = 18
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              reg_index;
  logic [COEF_WIDTH-1:0]   reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// ===== src/biq_coef_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module biq_coef_regs
  import biq_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  biq_cfg_if.sink                                        cfg_i,
  output logic [NUM_COEFS-1:0][COEF_FRAC_BITS+1:0]       coef_o
);

  localparam int unsigned COEF_W = COEF_FRAC_BITS + 2;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  logic [NUM_COEFS-1:0][COEF_W-1:0] coef_q;
  logic [NUM_COEFS-1:0][COEF_W-1:0] coef_d;

  // writes are always taken, unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  // register write decode
  always_comb begin
    coef_d = coef_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        IDX_B0:  coef_d[IDX_B0] = cfg_i.reg_data;
        IDX_B1:  coef_d[IDX_B1] = cfg_i.reg_data;
        IDX_B2:  coef_d[IDX_B2] = cfg_i.reg_data;
        IDX_A1:  coef_d[IDX_A1] = cfg_i.reg_data;
        IDX_A2:  coef_d[IDX_A2] = cfg_i.reg_data;
        default: coef_d = coef_q;
      endcase
    end
  end

  // b0 resets to unity gain, all others to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q         <= '0;
      coef_q[IDX_B0] <= COEF_ONE;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ===== src/biq_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module biq_core
  import biq_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH      = 16,
  parameter int unsigned COEF_FRAC_BITS    = 16,
  parameter int unsigned HISTORY_FRAC_BITS = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [NUM_COEFS-1:0][COEF_FRAC_BITS+1:0] coef_i,
  biq_sample_if.sink                                 sample_i,
  biq_filt_if.source                                 filtered_o
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned CF  = COEF_FRAC_BITS;
  localparam int unsigned HF  = HISTORY_FRAC_BITS;
  localparam int unsigned CW  = CF + 2;
  localparam int unsigned HW  = SW + HF;
  localparam int unsigned FFW = CW + SW;
  localparam int unsigned FBW = CW + HW;
  localparam int unsigned AW  = FBW + 3;

  localparam logic signed [HW-1:0] HIST_MAX = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] HIST_MIN = {1'b1, {(HW-1){1'b0}}};
  localparam logic signed [SW-1:0] OUT_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] OUT_MIN  = {1'b1, {(SW-1){1'b0}}};

  // input register
  logic                 s1_valid_q;
  logic signed [SW-1:0] s1_sample_q;

  // filter history
  logic                 primed_q;
  logic signed [SW-1:0] x1_q, x2_q;
  logic signed [HW-1:0] y1_q, y2_q;

  // result register
  logic                 out_valid_q;
  logic signed [SW-1:0] out_filt_q;

  logic                 advance;
  logic signed [HW-1:0] x_hist;
  logic signed [SW-1:0] x1, x2;
  logic signed [HW-1:0] y1, y2;
  logic signed [CW-1:0] b0, b1, b2, a1, a2;
  logic signed [FFW-1:0] p_b0, p_b1, p_b2;
  logic signed [FBW-1:0] p_a1, p_a2;
  logic signed [AW-1:0] ff_sum, acc, rnd_hist, rnd_out;
  logic                 hist_ovf, out_ovf;
  logic signed [HW-1:0] y_new;
  logic signed [SW-1:0] filt_new;

  // a word moves into the result register when that register is free or drained
  assign advance        = s1_valid_q && (!out_valid_q || filtered_o.ready);
  assign sample_i.ready = !s1_valid_q || advance;

  assign filtered_o.valid    = out_valid_q;
  assign filtered_o.filtered = out_filt_q;

  // first sample after reset stands in for the whole history
  assign x_hist = HW'(s1_sample_q) <<< HF;
  assign x1 = primed_q ? x1_q : s1_sample_q;
  assign x2 = primed_q ? x2_q : s1_sample_q;
  assign y1 = primed_q ? y1_q : x_hist;
  assign y2 = primed_q ? y2_q : x_hist;

  assign b0 = signed'(coef_i[IDX_B0]);
  assign b1 = signed'(coef_i[IDX_B1]);
  assign b2 = signed'(coef_i[IDX_B2]);
  assign a1 = signed'(coef_i[IDX_A1]);
  assign a2 = signed'(coef_i[IDX_A2]);

  // five products and one sum, feedforward aligned to the history fraction
  always_comb begin
    p_b0   = b0 * s1_sample_q;
    p_b1   = b1 * x1;
    p_b2   = b2 * x2;
    p_a1   = a1 * y1;
    p_a2   = a2 * y2;
    ff_sum = AW'(p_b0) + AW'(p_b1) + AW'(p_b2);
    acc    = (ff_sum <<< HF) - AW'(p_a1) - AW'(p_a2);
  end

  // round half up, then saturate for history and for output separately
  always_comb begin
    rnd_hist = (acc + (AW'(1) << (CF - 1))) >>> CF;
    rnd_out  = (acc + (AW'(1) << (CF + HF - 1))) >>> (CF + HF);
    hist_ovf = !((&rnd_hist[AW-1:HW-1]) || !(|rnd_hist[AW-1:HW-1]));
    out_ovf  = !((&rnd_out[AW-1:SW-1]) || !(|rnd_out[AW-1:SW-1]));
    if (hist_ovf) begin
      y_new = rnd_hist[AW-1] ? HIST_MIN : HIST_MAX;
    end else begin
      y_new = rnd_hist[HW-1:0];
    end
    if (out_ovf) begin
      filt_new = rnd_out[AW-1] ? OUT_MIN : OUT_MAX;
    end else begin
      filt_new = rnd_out[SW-1:0];
    end
  end

  // control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      primed_q    <= 1'b0;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (filtered_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        primed_q <= 1'b1;
        x2_q     <= x1;
        x1_q     <= s1_sample_q;
        y2_q     <= y1;
        y1_q     <= y_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      s1_sample_q <= sample_i.sample;
    end
    if (advance) begin
      out_filt_q <= filt_new;
    end
  end

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after a word advanced");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !filtered_o.ready) |-> !advance)
    else $error("stalled result overwritten");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> sample_i.ready)
    else $error("input stalled while input register empty");

  a_prime_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(primed_q) |-> $past(advance))
    else $error("history primed without a sample");

endmodule

`default_nettype wire

// ===== src/biquad_lowpass_primed_top.sv =====
// pipeline: a sample is registered in the input register, then its result in the result register
// throughput: one sample per cycle while the result side is ready, set by the feedback through the
//   five multipliers, the sum and the round/saturate into the history registers
// reset: coefficients load b0 = 1.0 and all others 0, history is unprimed;
//   the first sample after reset stands in for all four history entries
`timescale 1ns / 1ps
`default_nettype none

module biquad_lowpass_primed_top
  import biq_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH      = 16,
  parameter int unsigned COEF_FRAC_BITS    = 16,
  parameter int unsigned HISTORY_FRAC_BITS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  biq_cfg_if.sink     cfg_i,
  biq_sample_if.sink  sample_i,
  biq_filt_if.source  filtered_o
);

  logic [NUM_COEFS-1:0][COEF_FRAC_BITS+1:0] coef;

  // coefficient registers
  biq_coef_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_coef_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  // filter datapath
  biq_core #(
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .COEF_FRAC_BITS    (COEF_FRAC_BITS),
    .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef),
    .sample_i   (sample_i),
    .filtered_o (filtered_o)
  );

endmodule

`default_nettype wire

// ===== tb/biquad_lowpass_primed_top_tb.sv =====
`timescale 1ns / 1ps

module biquad_lowpass_primed_top_tb;
  import biq_pkg::*;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_FRAC = 16;
  localparam int unsigned HIST_FRAC = 8;
  localparam int unsigned COEF_W    = COEF_FRAC + 2;
  localparam int unsigned HIST_W    = SAMPLE_W + HIST_FRAC;

  localparam int COEF_MAX  = 131071;
  localparam int COEF_MIN  = -131072;
  localparam int COEF_ONE  = 65536;
  localparam int COEF_HALF = 32768;

  localparam int unsigned TOP_IDX     = (1 << COEF_IDX_W) - 1;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SHOWN_MAX   = 10;

  // filter state mirror and queue of filtered words still to come
  class filter_tracker;
    logic signed [COEF_W-1:0]   coef [NUM_COEFS];
    logic signed [SAMPLE_W-1:0] x_one, x_two;
    logic signed [HIST_W-1:0]   y_one, y_two;
    bit                         primed;
    logic signed [SAMPLE_W-1:0] expected_filtered [$];
    int unsigned                mismatches;
    int unsigned                results_seen;

    function new();
      foreach (coef[i]) coef[i] = '0;
      coef[IDX_B0] = COEF_W'(COEF_ONE);
      x_one = '0;
      x_two = '0;
      y_one = '0;
      y_two = '0;
      primed = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    static function longint round_half_up(longint v, int unsigned s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint clamp(longint v, int unsigned w);
      longint maxv;
      longint minv;
      maxv = (longint'(1) <<< (w - 1)) - 1;
      minv = -maxv - 1;
      if (v > maxv) return maxv;
      if (v < minv) return minv;
      return v;
    endfunction

    function int pending();
      return expected_filtered.size();
    endfunction

    // writes beyond the last coefficient are dropped
    function void write_coef(logic [COEF_IDX_W-1:0] idx, logic [COEF_W-1:0] d);
      if (idx < NUM_COEFS) coef[idx] = d;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      longint                   ff;
      longint                   fb;
      longint                   acc;
      logic signed [HIST_W-1:0] y_new;
      // first word after reset fills the whole history with itself
      if (!primed) begin
        x_one = x;
        x_two = x;
        y_one = HIST_W'(longint'(x) <<< HIST_FRAC);
        y_two = y_one;
        primed = 1'b1;
      end
      ff = longint'(coef[IDX_B0]) * longint'(x)
         + longint'(coef[IDX_B1]) * longint'(x_one)
         + longint'(coef[IDX_B2]) * longint'(x_two);
      fb = longint'(coef[IDX_A1]) * longint'(y_one)
         + longint'(coef[IDX_A2]) * longint'(y_two);
      acc = (ff <<< HIST_FRAC) - fb;
      // history and output are both rounded from the full sum
      y_new = HIST_W'(clamp(round_half_up(acc, COEF_FRAC), HIST_W));
      expected_filtered.push_back(
        SAMPLE_W'(clamp(round_half_up(acc, COEF_FRAC + HIST_FRAC), SAMPLE_W)));
      x_two = x_one;
      x_one = x;
      y_two = y_one;
      y_one = y_new;
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= SHOWN_MAX) $display("[%0t] %s", $realtime, msg);
    endfunction

    function void check_filtered(logic signed [SAMPLE_W-1:0] y);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_filtered.size() == 0) begin
        note_mismatch($sformatf("filtered word %0d with nothing pending", y));
      end else begin
        want = expected_filtered.pop_front();
        if (y !== want)
          note_mismatch($sformatf("filtered word %0d: expected %0d, got %0d",
                                  results_seen, want, y));
      end
      results_seen++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  biq_cfg_if    #(.COEF_WIDTH(COEF_W))     cfg_if ();
  biq_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) smp_if ();
  biq_filt_if   #(.SAMPLE_WIDTH(SAMPLE_W)) filt_if ();

  filter_tracker tracker;
  bit            sender_steady;
  bit            long_hold_req;

  biquad_lowpass_primed_top #(
    .SAMPLE_WIDTH     (SAMPLE_W),
    .COEF_FRAC_BITS   (COEF_FRAC),
    .HISTORY_FRAC_BITS(HIST_FRAC)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_if),
    .sample_i  (smp_if),
    .filtered_o(filt_if)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // mostly no gap, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int rnd_signed(int unsigned mag);
    return int'($urandom_range(0, 2 * mag)) - int'(mag);
  endfunction

  function automatic int coef_extreme();
    case ($urandom_range(0, 4))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  // full range, held value, rails or small values
  function automatic logic signed [SAMPLE_W-1:0] next_sample(logic signed [SAMPLE_W-1:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return SAMPLE_W'($urandom);
    if (r < 70) return prev;
    if (r < 85) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return SAMPLE_W'(rnd_signed(256));
  endfunction

  // bookkeeping of every accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) tracker.write_coef(cfg_if.reg_index, cfg_if.reg_data);
      if (smp_if.valid && smp_if.ready) tracker.note_sample(smp_if.sample);
      if (filt_if.valid && filt_if.ready) tracker.check_filtered(filt_if.filtered);
    end
  end

  // result side back-pressure, with one long hold-off on request
  initial begin : filtered_sink
    int unsigned stall;
    filt_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_len();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        filt_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stall > 0) begin
        filt_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      filt_if.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 10))
        @(posedge clk_i);
    end
  end

  // offer one sample word and wait for it to be taken
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
    int unsigned gap;
    gap = sender_steady ? 0 : idle_len();
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= x;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  // stop sending until every filtered word is back
  task automatic drain();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // write all five coefficients from a random start, maybe one stray index too
  task automatic load_coefs(input int b0, input int b1, input int b2, input int a1,
                            input int a2, input bit stray);
    logic [COEF_W-1:0] c [NUM_COEFS];
    int unsigned       first;
    int unsigned       idx;
    c[IDX_B0] = COEF_W'(b0);
    c[IDX_B1] = COEF_W'(b1);
    c[IDX_B2] = COEF_W'(b2);
    c[IDX_A1] = COEF_W'(a1);
    c[IDX_A2] = COEF_W'(a2);
    first = $urandom_range(0, NUM_COEFS - 1);
    for (int k = 0; k < NUM_COEFS; k++) begin
      idx = (first + k) % NUM_COEFS;
      cfg_if.valid     <= 1'b1;
      cfg_if.reg_index <= COEF_IDX_W'(idx);
      cfg_if.reg_data  <= c[idx];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    if (stray) begin
      cfg_if.reg_index <= COEF_IDX_W'($urandom_range(NUM_COEFS, TOP_IDX));
      cfg_if.reg_data  <= COEF_W'($urandom);
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] x;
    int unsigned                kind;
    tracker = new();
    sender_steady = 1'b0;
    long_hold_req = 1'b0;
    smp_if.valid     <= 1'b0;
    smp_if.sample    <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= IDX_B0;
    cfg_if.reg_data  <= '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients pass the priming word straight through
    push_sample(16'sd12345);
    drain();

    // half of two-back input plus half of two-back output shows the priming
    load_coefs(0, 0, COEF_HALF, 0, -COEF_HALF, 1'b0);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sd0);
    push_sample(16'sd1);
    drain();

    // all coefficients at the top: unstable, saturates
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh8000);
    push_sample(16'sd100);
    drain();

    // all coefficients at the bottom
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b1);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(-16'sd1);
    push_sample(16'sd0);
    drain();

    // gain of one half: odd inputs land on ties
    load_coefs(COEF_HALF, 0, 0, 0, 0, 1'b0);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_sample(16'sd3);
    drain();

    // random phases, each with its own coefficient set
    x = '0;
    for (int ph = 0; ph < 10; ph++) begin
      kind = (ph < 4) ? ph : $urandom_range(0, 3);
      case (kind)
        0: load_coefs(4424, 8848, 4424, -74898, 27054, $urandom_range(0, 1));
        1: load_coefs(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom), $urandom_range(0, 1));
        2: load_coefs(coef_extreme(), coef_extreme(), coef_extreme(), coef_extreme(),
                      coef_extreme(), $urandom_range(0, 1));
        default: load_coefs(rnd_signed(30000), rnd_signed(30000), rnd_signed(30000),
                            -int'($urandom_range(40000, 120000)),
                            $urandom_range(0, 60000), $urandom_range(0, 1));
      endcase
      sender_steady = (ph == 3) || ($urandom_range(0, 3) == 0);
      // the result side holds off while samples keep coming
      if (ph == 3) begin
        long_hold_req = 1'b1;
        wait (!long_hold_req);
      end
      for (int i = 0; i < 93; i++) begin
        if (ph == 5 && i == 46) drain();
        x = next_sample(x);
        push_sample(x);
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
